// ===== src/cgs_pkg.sv =====
`default_nettype none

package cgs_pkg;

  // spacing register width
  localparam int SP_W = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_LOW  = 2'd0,
    REG_BAND_HIGH = 2'd1,
    REG_SPACING   = 2'd2
  } cgs_reg_t;

  // reset values of the band registers and the spacing
  localparam int unsigned RST_BAND_LOW  = 87500;
  localparam int unsigned RST_BAND_HIGH = 108000;
  localparam logic [SP_W-1:0] RST_SPACING = 16'd100;

  // per-word flags that ride along the pipe
  typedef struct packed {
    logic up;        // step direction
    logic in_band;   // input lay inside [low, high]
    logic sp_zero;   // spacing was zero: pass through
    logic inverted;  // low above high: no channel exists
  } cgs_flags_t;

  // one restoring-division step: shift in a dividend bit, subtract spacing if it fits
  function automatic logic [SP_W-1:0] rem_step(input logic [SP_W-1:0] rem,
                                               input logic            din,
                                               input logic [SP_W-1:0] sp);
    logic [SP_W:0] t;
    logic [SP_W:0] diff;
    t    = {rem, din};
    diff = t - {1'b0, sp};
    if (t >= {1'b0, sp}) begin
      rem_step = diff[SP_W-1:0];
    end else begin
      rem_step = t[SP_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/cgs_in_if.sv =====
`default_nettype none

interface cgs_in_if #(
  parameter int W = 17
);
  logic         valid;
  logic         ready;
  logic [W-1:0] freq_khz;
  logic         step_up;

  modport source (output valid, output freq_khz, output step_up, input ready);
  modport sink   (input valid, input freq_khz, input step_up, output ready);
endinterface

`default_nettype wire

// ===== src/cgs_out_if.sv =====
`default_nettype none

interface cgs_out_if #(
  parameter int W = 17
);
  logic         valid;
  logic         ready;
  logic [W-1:0] next_khz;
  logic         on_grid;

  modport source (output valid, output next_khz, output on_grid, input ready);
  modport sink   (input valid, input next_khz, input on_grid, output ready);
endinterface

`default_nettype wire

// ===== src/cgs_cfg_if.sv =====
`default_nettype none

interface cgs_cfg_if #(
  parameter int W = 17
);
  import cgs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/cgs_cell.sv =====
`default_nettype none

// One remainder cell: takes the top bit of both dividends, one division step each.
module cgs_cell #(
  parameter int W = 17
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [cgs_pkg::SP_W-1:0]    sp,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [cgs_pkg::SP_W-1:0]    up_rd,
  input  wire logic [cgs_pkg::SP_W-1:0]    up_rh,
  input  wire logic [W-1:0]                up_dsh,
  input  wire logic [W-1:0]                up_hsh,
  input  wire logic [W-1:0]                up_fc,
  input  wire cgs_pkg::cgs_flags_t         up_flags,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output logic [cgs_pkg::SP_W-1:0]         dn_rd,
  output logic [cgs_pkg::SP_W-1:0]         dn_rh,
  output logic [W-1:0]                     dn_dsh,
  output logic [W-1:0]                     dn_hsh,
  output logic [W-1:0]                     dn_fc,
  output cgs_pkg::cgs_flags_t              dn_flags
);
  import cgs_pkg::*;

  logic            valid_r;
  logic [SP_W-1:0] rd_r, rh_r, rd_nxt, rh_nxt;
  logic [W-1:0]    dsh_r, hsh_r, fc_r;
  cgs_flags_t      flags_r;
  logic            take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  assign rd_nxt = rem_step(up_rd, up_dsh[W-1], sp);
  assign rh_nxt = rem_step(up_rh, up_hsh[W-1], sp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_r    <= rd_nxt;
      rh_r    <= rh_nxt;
      dsh_r   <= {up_dsh[W-2:0], 1'b0};
      hsh_r   <= {up_hsh[W-2:0], 1'b0};
      fc_r    <= up_fc;
      flags_r <= up_flags;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rd    = rd_r;
  assign dn_rh    = rh_r;
  assign dn_dsh   = dsh_r;
  assign dn_hsh   = hsh_r;
  assign dn_fc    = fc_r;
  assign dn_flags = flags_r;

endmodule

`default_nettype wire

// ===== src/cgs_finish.sv =====
`default_nettype none

// Turns the remainders into the stepped frequency: base/top stage, then output register.
module cgs_finish #(
  parameter int W = 17
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [W-1:0]             lo,
  input  wire logic [W-1:0]             hi,
  input  wire logic [cgs_pkg::SP_W-1:0] sp,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire logic [cgs_pkg::SP_W-1:0] up_rd,
  input  wire logic [cgs_pkg::SP_W-1:0] up_rh,
  input  wire logic [W-1:0]             up_fc,
  input  wire cgs_pkg::cgs_flags_t      up_flags,
  cgs_out_if.source                     out_ch
);
  import cgs_pkg::*;

  localparam int PAD = W - SP_W;

  // stage 1: grid base below the clamped input and the highest grid point
  logic         s1_valid_r;
  logic [W-1:0] base_r, top_r, fc_r;
  logic         grid_r;
  cgs_flags_t   flags_r;
  logic         s1_ready;

  // stage 2: output word
  logic         out_valid_r;
  logic [W-1:0] next_r, next_nxt;
  logic         on_grid_r;

  logic [W-1:0] sp_w;
  logic [W:0]   sum_up;
  logic [W-1:0] up_val, dn_val;

  assign sp_w     = {{PAD{1'b0}}, sp};
  assign up_ready = !s1_valid_r || s1_ready;
  assign s1_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (up_ready) begin
      s1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      base_r  <= up_fc - {{PAD{1'b0}}, up_rd};
      top_r   <= hi - {{PAD{1'b0}}, up_rh};
      fc_r    <= up_fc;
      flags_r <= up_flags;
      grid_r  <= up_flags.in_band && !up_flags.sp_zero && !up_flags.inverted &&
                 (up_rd == '0);
    end
  end

  // up past the top wraps to low; down from the first channel wraps to the top point
  assign sum_up = {1'b0, base_r} + {1'b0, sp_w};
  assign up_val = (sum_up > {1'b0, hi}) ? lo : sum_up[W-1:0];
  assign dn_val = (base_r == lo) ? top_r : (base_r - sp_w);

  always_comb begin
    if (flags_r.sp_zero) begin
      next_nxt = fc_r;
    end else if (flags_r.inverted) begin
      next_nxt = lo;
    end else if (flags_r.up) begin
      next_nxt = up_val;
    end else begin
      next_nxt = dn_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_ready) begin
      next_r    <= next_nxt;
      on_grid_r <= grid_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.next_khz = next_r;
  assign out_ch.on_grid  = on_grid_r;

`ifndef NO_ASSERTIONS
  a_rst_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid_r && !s1_valid_r)
    else $error("finish pipe not empty after reset");
  a_grid_flags: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && grid_r |-> flags_r.in_band && !flags_r.sp_zero && !flags_r.inverted)
    else $error("on-grid set for an off-band or disabled word");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(base_r) && $stable(flags_r))
    else $error("stage 1 word lost while stalled");
`endif

endmodule

`default_nettype wire

// ===== src/channel_grid_stepper_unit.sv =====
`default_nettype none

// Registers: front stage, remainder cells, finish stage 1, output register.
// One word per cycle unless stalled; the remainder chain has one cell per dividend bit.
// Each stage has its own valid and stalls only when its successor is full.
// Reset (rst_n low, synchronous): pipe emptied; band 87500..108000 kHz, spacing 100 kHz.
// Configuration port is always ready; write it only with the pipe drained.
module channel_grid_stepper_unit #(
  parameter int FREQ_WIDTH = 17
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cgs_cfg_if.sink   cfg_ch,
  cgs_in_if.sink    in_ch,
  cgs_out_if.source out_ch
);
  import cgs_pkg::*;

  localparam int W = FREQ_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [W-1:0]    lo_r, hi_r;
  logic [SP_W-1:0] sp_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= W'(RST_BAND_LOW);
      hi_r <= W'(RST_BAND_HIGH);
      sp_r <= RST_SPACING;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BAND_LOW:  lo_r <= cfg_ch.data;
        REG_BAND_HIGH: hi_r <= cfg_ch.data;
        REG_SPACING:   sp_r <= cfg_ch.data[SP_W-1:0];
        default:       ;  // unused index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Front stage: clamp into band, form the two dividends.
  //   d  = clamped - low  -> remainder gives the grid base below the input
  //   hr = high - low     -> remainder gives the highest grid point
  // With zero spacing the raw input rides in fc and comes out untouched.
  // ---------------------------------------------------------------------------
  logic         fr_valid_r;
  logic [W-1:0] fr_fc_r, fr_d_r, fr_hr_r;
  cgs_flags_t   fr_flags_r, fr_flags_nxt;
  logic [W-1:0] fc_nxt, d_nxt, clamp;
  logic         below, above;
  logic         c0_ready;

  assign below = in_ch.freq_khz < lo_r;
  assign above = in_ch.freq_khz > hi_r;

  always_comb begin
    if (below) begin
      clamp = lo_r;
      d_nxt = '0;
    end else if (above) begin
      clamp = hi_r;
      d_nxt = hi_r - lo_r;
    end else begin
      clamp = in_ch.freq_khz;
      d_nxt = in_ch.freq_khz - lo_r;
    end
  end

  assign fr_flags_nxt.up       = in_ch.step_up;
  assign fr_flags_nxt.in_band  = !below && !above;
  assign fr_flags_nxt.sp_zero  = (sp_r == '0);
  assign fr_flags_nxt.inverted = lo_r > hi_r;
  assign fc_nxt = fr_flags_nxt.sp_zero ? in_ch.freq_khz : clamp;

  assign in_ch.ready = !fr_valid_r || c0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      fr_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      fr_fc_r    <= fc_nxt;
      fr_d_r     <= d_nxt;
      fr_hr_r    <= hi_r - lo_r;
      fr_flags_r <= fr_flags_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Remainder chain: W cells, each retires one dividend bit per word.
  // Link k feeds cell k; link W feeds the finish block.
  // ---------------------------------------------------------------------------
  logic            lk_valid [0:W];
  logic            lk_ready [0:W];
  logic [SP_W-1:0] lk_rd    [0:W];
  logic [SP_W-1:0] lk_rh    [0:W];
  logic [W-1:0]    lk_dsh   [0:W];
  logic [W-1:0]    lk_hsh   [0:W];
  logic [W-1:0]    lk_fc    [0:W];
  cgs_flags_t      lk_flags [0:W];

  assign lk_valid[0] = fr_valid_r;
  assign lk_rd[0]    = '0;
  assign lk_rh[0]    = '0;
  assign lk_dsh[0]   = fr_d_r;
  assign lk_hsh[0]   = fr_hr_r;
  assign lk_fc[0]    = fr_fc_r;
  assign lk_flags[0] = fr_flags_r;
  assign c0_ready    = lk_ready[0];

  for (genvar k = 0; k < W; k++) begin : g_cell
    cgs_cell #(.W(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .sp       (sp_r),
      .up_valid (lk_valid[k]),
      .up_ready (lk_ready[k]),
      .up_rd    (lk_rd[k]),
      .up_rh    (lk_rh[k]),
      .up_dsh   (lk_dsh[k]),
      .up_hsh   (lk_hsh[k]),
      .up_fc    (lk_fc[k]),
      .up_flags (lk_flags[k]),
      .dn_valid (lk_valid[k+1]),
      .dn_ready (lk_ready[k+1]),
      .dn_rd    (lk_rd[k+1]),
      .dn_rh    (lk_rh[k+1]),
      .dn_dsh   (lk_dsh[k+1]),
      .dn_hsh   (lk_hsh[k+1]),
      .dn_fc    (lk_fc[k+1]),
      .dn_flags (lk_flags[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Finish: grid base, wrap decisions, output register
  // ---------------------------------------------------------------------------
  cgs_finish #(.W(W)) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .lo       (lo_r),
    .hi       (hi_r),
    .sp       (sp_r),
    .up_valid (lk_valid[W]),
    .up_ready (lk_ready[W]),
    .up_rd    (lk_rd[W]),
    .up_rh    (lk_rh[W]),
    .up_fc    (lk_fc[W]),
    .up_flags (lk_flags[W]),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_rst_front: assert property (@(posedge clk) $past(!rst_n) |-> !fr_valid_r)
    else $error("front stage not empty after reset");
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> fr_valid_r)
    else $error("accepted word not captured in front stage");
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid_r && !c0_ready |=> fr_valid_r && $stable(fr_fc_r) && $stable(fr_d_r))
    else $error("front word changed while chain stalled");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cgs_pkg::*;

  localparam int FREQ_W     = 17;
  localparam int LATENCY    = FREQ_W + 3;  // accept to result valid: front, cells, finish stage 1, output
  localparam int PHASE_WORDS = 64;         // random words per configuration phase
  localparam int RAND_PHASES = 24;
  localparam int BAND_MIN   = 64000;       // range of band edges the test writes
  localparam int BAND_MAX   = 129535;

  // index 3 decodes to no register; a write there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [FREQ_W-1:0] khz_t;

  typedef struct packed {
    khz_t next_khz;
    logic on_grid;
  } step_res_t;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_t;

  // one row of the directed table: either a register write or a stimulus word
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    khz_t                 data;
    khz_t                 freq;
    logic                 up;
    bit                   known;  // res holds a hand-written expectation
    step_res_t            res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cgs_cfg_if #(.W(FREQ_W)) cfg_ch ();
  cgs_in_if  #(.W(FREQ_W)) in_ch ();
  cgs_out_if #(.W(FREQ_W)) out_ch ();

  channel_grid_stepper_unit #(
    .FREQ_WIDTH(FREQ_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the band registers, updated on every accepted write
  khz_t            band_lo;
  khz_t            band_hi;
  logic [SP_W-1:0] spacing;

  step_res_t pending_steps[$];  // expected result words, oldest first
  plan_row_t plan[$];
  int        mismatches = 0;
  bit        no_idle = 1'b0;    // when set, neither side inserts gaps

  // clamp into the band, floor onto the grid, then move one channel
  function automatic step_res_t predict_step(khz_t f, logic up);
    longint unsigned lo, hi, sp, fc, idx, nxt;
    step_res_t       r;
    lo = band_lo;
    hi = band_hi;
    sp = spacing;
    r.on_grid = 1'b0;
    if (sp != 0 && lo <= hi && f >= lo && f <= hi) begin
      r.on_grid = ((f - lo) % sp) == 0;
    end
    if (sp == 0) begin
      r.next_khz = f;                 // stepping off: pass through
    end else if (lo > hi) begin
      r.next_khz = khz_t'(lo);        // inverted band: no channel at all
    end else begin
      fc = f;
      if (fc < lo) fc = lo;
      if (fc > hi) fc = hi;
      idx = (fc - lo) / sp;
      if (up) begin
        nxt = lo + (idx + 1) * sp;
        if (nxt > hi) nxt = lo;       // past the top: back to the low edge
      end else if (idx == 0) begin
        nxt = lo + ((hi - lo) / sp) * sp;  // below first channel: highest grid point
      end else begin
        nxt = lo + (idx - 1) * sp;
      end
      r.next_khz = khz_t'(nxt);
    end
    return r;
  endfunction

  // grid points, band edges and neighbors, field ends, or anywhere in the field
  function automatic khz_t pick_freq();
    int unsigned sel;
    int unsigned span;
    sel  = $urandom_range(0, 9);
    span = (band_hi >= band_lo) ? band_hi - band_lo : 0;
    if (spacing != 0 && band_hi >= band_lo && sel < 4) begin
      return khz_t'(band_lo + $urandom_range(0, span / spacing) * spacing);
    end
    if (sel < 6) begin
      case ($urandom_range(0, 5))
        0: return band_lo;
        1: return band_hi;
        2: return khz_t'(band_lo - 1);
        3: return khz_t'(band_hi + 1);
        4: return '0;
        default: return '1;
      endcase
    end
    return khz_t'($urandom_range(0, (1 << FREQ_W) - 1));
  endfunction

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, khz_t val);
    plan.push_back('{kind: ROW_CFG, idx: idx, data: val, freq: '0, up: 1'b0,
                     known: 1'b0, res: '0});
  endtask

  task automatic add_word(khz_t f, logic up, bit known, khz_t nxt, logic on);
    plan.push_back('{kind: ROW_WORD, idx: '0, data: '0, freq: f, up: up,
                     known: known, res: '{next_khz: nxt, on_grid: on}});
  endtask

  // offer one word after a random gap; the expectation is queued at the accept edge
  task automatic send_word(khz_t f, logic up, bit known, step_res_t res);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.freq_khz <= f;
    in_ch.step_up  <= up;
    do @(posedge clk); while (!in_ch.ready);
    pending_steps.push_back(known ? res : predict_step(f, up));
  endtask

  // stop offering words and wait until every expected word has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_steps.size() != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, khz_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_BAND_LOW:  band_lo = val;
      REG_BAND_HIGH: band_hi = val;
      REG_SPACING:   spacing = val[SP_W-1:0];
      default: ;     // unmapped index: dropped
    endcase
    @(posedge clk);  // keeps the next write's valid edge in a later step
  endtask

  // result side: random stall before each word, then check against the oldest expectation
  initial begin : result_sink
    int unsigned stall;
    step_res_t   want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_steps.size() == 0) begin
        $error("unexpected result word: next_khz %0d on_grid %0b",
               out_ch.next_khz, out_ch.on_grid);
        mismatches++;
      end else begin
        want = pending_steps.pop_front();
        if (out_ch.next_khz !== want.next_khz) begin
          $error("next_khz: expected %0d, got %0d", want.next_khz, out_ch.next_khz);
          mismatches++;
        end
        if (out_ch.on_grid !== want.on_grid) begin
          $error("on_grid: expected %0b, got %0b", want.on_grid, out_ch.on_grid);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned lo_v, hi_v, sp_v, tmp;
    in_ch.valid    <= 1'b0;
    in_ch.freq_khz <= '0;
    in_ch.step_up  <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    rst_n          <= 1'b0;
    band_lo = khz_t'(RST_BAND_LOW);
    band_hi = khz_t'(RST_BAND_HIGH);
    spacing = RST_SPACING;

    // reset band 87500..108000, 100 kHz grid
    add_word(87500,  1'b1, 1'b1, 87600,  1'b1);
    add_word(87500,  1'b0, 1'b1, 108000, 1'b1);  // first channel down wraps to top
    add_word(108000, 1'b1, 1'b1, 87500,  1'b1);  // top up wraps to low edge
    add_word(108000, 1'b0, 1'b1, 107900, 1'b1);
    add_word(0,      1'b1, 1'b1, 87600,  1'b0);  // below band clamps to low edge
    add_word(0,      1'b0, 1'b1, 108000, 1'b0);
    add_word('1,     1'b0, 1'b1, 107900, 1'b0);  // above band clamps to high edge
    add_word('1,     1'b1, 1'b1, 87500,  1'b0);
    add_word(87550,  1'b1, 1'b0, '0, 1'b0);      // off grid, floored
    add_word(87550,  1'b0, 1'b0, '0, 1'b0);
    add_word(99999,  1'b0, 1'b0, '0, 1'b0);
    // zero spacing passes the word through
    add_cfg(REG_SPACING, 0);
    add_word(99999,  1'b1, 1'b1, 99999,  1'b0);
    add_word('1,     1'b0, 1'b1, '1,     1'b0);
    add_word(0,      1'b1, 1'b1, 0,      1'b0);
    // register extremes: exactly two channels
    add_cfg(REG_BAND_LOW,  BAND_MIN);
    add_cfg(REG_BAND_HIGH, BAND_MAX);
    add_cfg(REG_SPACING,   (1 << SP_W) - 1);
    add_word(BAND_MIN, 1'b1, 1'b1, BAND_MAX, 1'b1);
    add_word(BAND_MAX, 1'b1, 1'b1, BAND_MIN, 1'b1);
    add_word(BAND_MAX, 1'b0, 1'b1, BAND_MIN, 1'b1);
    add_word(BAND_MIN, 1'b0, 1'b1, BAND_MAX, 1'b1);
    // inverted band: every word answers with the low edge
    add_cfg(REG_BAND_LOW,  120000);
    add_cfg(REG_BAND_HIGH, 90000);
    add_cfg(REG_SPACING,   7);
    add_word(100000, 1'b1, 1'b1, 120000, 1'b0);
    add_word(0,      1'b0, 1'b1, 120000, 1'b0);
    // write to the unmapped index must change nothing
    add_cfg(REG_UNUSED, 1);
    add_word(100000, 1'b0, 1'b1, 120000, 1'b0);
    // single-channel band
    add_cfg(REG_BAND_LOW,  100000);
    add_cfg(REG_BAND_HIGH, 100000);
    add_cfg(REG_SPACING,   1);
    add_word(100000, 1'b1, 1'b1, 100000, 1'b1);
    add_word(100000, 1'b0, 1'b1, 100000, 1'b1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].freq, plan[i].up, plan[i].known, plan[i].res);
      end
    end

    // random phases; each drains the pipe before rewriting all three registers
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          lo_v = RST_BAND_LOW;
          hi_v = RST_BAND_HIGH;
          sp_v = RST_SPACING;
        end
        1: begin
          lo_v = BAND_MIN;
          hi_v = BAND_MAX;
          sp_v = 1;
        end
        default: begin
          lo_v = $urandom_range(BAND_MIN, BAND_MAX);
          if ($urandom_range(0, 3) == 0) begin
            hi_v = lo_v + $urandom_range(0, 300);  // narrow band
            if (hi_v > BAND_MAX) hi_v = BAND_MAX;
          end else begin
            hi_v = $urandom_range(lo_v, BAND_MAX);
          end
          if ($urandom_range(0, 7) == 0) begin
            tmp  = lo_v;                           // occasionally inverted
            lo_v = hi_v + 1;
            hi_v = tmp;
            if (lo_v > BAND_MAX) lo_v = BAND_MAX;
          end
          case ($urandom_range(0, 7))
            0:       sp_v = $urandom_range(1, 16);
            1, 2, 3: sp_v = $urandom_range(17, 999);
            4:       sp_v = $urandom_range(1000, 20000);
            5:       sp_v = $urandom_range(1, (1 << SP_W) - 1);
            6:       sp_v = (1 << SP_W) - 1;
            default: sp_v = $urandom_range(50, 200);
          endcase
          if (p == 3) sp_v = 0;
        end
      endcase

      drain();
      no_idle = (p % 5) == 4;  // some phases run back to back on both sides
      write_reg(REG_BAND_LOW,  khz_t'(lo_v));
      write_reg(REG_BAND_HIGH, khz_t'(hi_v));
      write_reg(REG_SPACING,   khz_t'(sp_v));

      repeat (PHASE_WORDS) begin
        send_word(pick_freq(), logic'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #400_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/cgs_pkg.sv
src/cgs_in_if.sv
src/cgs_out_if.sv
src/cgs_cfg_if.sv
src/cgs_cell.sv
src/cgs_finish.sv
src/channel_grid_stepper_unit.sv
test/tb.sv
